// ----- design/multi_waveform_tone_generator_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the tone generator
// Short wrappers for clocked concurrent checks, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef MULTI_WAVEFORM_TONE_GENERATOR_MACROS_SVH
`define MULTI_WAVEFORM_TONE_GENERATOR_MACROS_SVH

// Consequent checked in the same cycle as the antecedent
`define MWTG_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent
`define MWTG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/mwtg_pkg.sv -----
// ----------------------------------------------------------------------------
// Tone generator package
// Widths, register indexes, sequencer states, control types and the
// fixed-point helpers shared by the tone generator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mwtg_pkg;

   // Field and datapath widths
   localparam int PHASE_W     = 32;
   localparam int STEP_W      = 32;
   localparam int MODE_W      = 2;
   localparam int GAIN_W      = 17;
   localparam int ALPHA_W     = 17;
   localparam int COUNT_W     = 24;
   localparam int SAMPLE_W    = 16;
   localparam int PREV_W      = 33;
   localparam int MUL_A_W     = 33;
   localparam int MUL_B_W     = 18;
   localparam int PROD_W      = MUL_A_W + MUL_B_W;
   localparam int ACC_W       = 52;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   // Quarter-wave sine table
   localparam int SINE_DEPTH  = 256;
   localparam int SINE_IDX_W  = $clog2(SINE_DEPTH);
   localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;
   localparam logic [63:0] TAYLOR_DIV [7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                              64'd110, 64'd156, 64'd210};

   // Sample limits and Q16 unity
   localparam int AMP_MAX = 32767;
   localparam int AMP_MIN = -32768;
   localparam logic [ALPHA_W-1:0] Q16_ONE = ALPHA_W'(65536);

   // Reset values of the configuration registers
   localparam logic [MODE_W-1:0]  RESET_WAVE_MODE  = MODE_W'(0);
   localparam logic [STEP_W-1:0]  RESET_PHASE_STEP = STEP_W'(42852281);
   localparam logic [GAIN_W-1:0]  RESET_GAIN       = GAIN_W'(65536);
   localparam logic [ALPHA_W-1:0] RESET_ALPHA      = ALPHA_W'(65536);
   localparam logic [COUNT_W-1:0] RESET_COUNT      = COUNT_W'(220500);

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_WAVE_MODE      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PHASE_STEP     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_AMPLITUDE_GAIN = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FILTER_ALPHA   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLE_COUNT   = 3'd4;

   // Wave modes
   localparam logic [MODE_W-1:0] MODE_SQUARE   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SAWTOOTH = 2'd1;
   localparam logic [MODE_W-1:0] MODE_TRIANGLE = 2'd2;
   localparam logic [MODE_W-1:0] MODE_SINE     = 2'd3;

   typedef struct packed {
      logic [MODE_W-1:0]  wave_mode;
      logic [STEP_W-1:0]  phase_step;
      logic [GAIN_W-1:0]  amplitude_gain;
      logic [ALPHA_W-1:0] filter_alpha;
      logic [COUNT_W-1:0] sample_count;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RAW_A,
      ST_RAW_B,
      ST_RAW_C,
      ST_GAIN,
      ST_SAT,
      ST_FILT_A,
      ST_FILT_B,
      ST_FILT_C,
      ST_FILT_D,
      ST_DONE
   } state_type;

   typedef struct packed {
      state_type state;
      logic      accept;
      logic      finish;
   } ctrl_type;

   // Divide by 2^16, rounding toward zero
   function automatic logic signed [ACC_W-1:0] trunc_q16(input logic signed [ACC_W-1:0] x);
      logic signed [ACC_W-1:0] bias;
      bias = x[ACC_W-1] ? {{(ACC_W-16){1'b0}}, 16'hFFFF} : '0;
      return (x + bias) >>> 16;
   endfunction

   // Divide by 2^32, rounding toward zero
   function automatic logic signed [ACC_W-1:0] trunc_q32(input logic signed [ACC_W-1:0] x);
      logic signed [ACC_W-1:0] bias;
      bias = x[ACC_W-1] ? {{(ACC_W-32){1'b0}}, 32'hFFFF_FFFF} : '0;
      return (x + bias) >>> 32;
   endfunction

   // Quarter-wave sine entry k, Q30 Taylor series, evaluated at elaboration
   function automatic logic [SAMPLE_W-1:0] sine_value(input int unsigned k);
      logic [63:0]        x;
      logic [63:0]        term;
      logic signed [63:0] sum;
      logic [63:0]        v;
      x    = (64'(k) * Q30_HALF_PI) / SINE_DEPTH;
      term = x;
      sum  = $signed(x);
      for (int n = 0; n < 7; n++) begin
         term = (term * x) >> 30;
         term = (term * x) >> 30;
         term = term / TAYLOR_DIV[n];
         if (n % 2 == 0) begin
            sum = sum - $signed(term);
         end else begin
            sum = sum + $signed(term);
         end
      end
      if (sum < 0) begin
         sum = '0;
      end
      v = ($unsigned(sum) * 64'd32767) >> 30;
      if (v > 64'd32767) begin
         v = 64'd32767;
      end
      return v[SAMPLE_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ----- design/multi_waveform_tone_generator.sv -----
// ----------------------------------------------------------------------------
// Multi-waveform tone generator
// Phase-accumulator tone source (square, squared sawtooth, triangle, sine)
// with Q16 gain, saturation and a one-pole low-pass filter.
// ----------------------------------------------------------------------------
// Usage:
//   Each request (req_valid, req_stall, req_restart) yields one response
//   (rsp_valid, rsp_stall, rsp_sample, rsp_last). req_restart clears the
//   phase, square toggle, sample index and filter before that sample.
//   rsp_last marks the final sample of a buffer of sample_count samples,
//   after which the run starts afresh.
//   Registers are written through csr_write_enable / csr_index / csr_wdata
//   while no request is in flight.
//   A request steps through the waveform, gain, saturation and filter
//   states (and ST_RAW_B for the squared sawtooth) before its response is
//   registered. No new request is taken until the last has finished, as
//   one shared multiplier serves waveform, gain and three filter products.
//   req_stall is high while a request is being worked on.
//   A stalled response holds in the output register; the next request may
//   be taken meanwhile and waits at its last step until the register frees.
//   Reset loads the register defaults and clears the run state.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_waveform_tone_generator (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic                                  req_restart,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic signed [mwtg_pkg::SAMPLE_W-1:0]       rsp_sample,
   output logic                                       rsp_last,
   input  wire logic                                  csr_write_enable,
   input  wire logic [mwtg_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [mwtg_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   mwtg_pkg::cfg_type  cfg;
   mwtg_pkg::ctrl_type ctrl;

   // Configuration registers
   mwtg_regs u_regs (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .cfg              (cfg)
   );

   // Sequencer
   mwtg_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .wave_mode (cfg.wave_mode),
      .ctrl      (ctrl)
   );

   // Datapath
   mwtg_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .cfg         (cfg),
      .req_restart (req_restart),
      .rsp_sample  (rsp_sample),
      .rsp_last    (rsp_last)
   );

endmodule

`default_nettype wire

// ----- design/mwtg_regs.sv -----
// ----------------------------------------------------------------------------
// Tone generator configuration registers
// Decodes the write port and holds mode, step, gain, alpha and count.
// ----------------------------------------------------------------------------
`default_nettype none

module mwtg_regs (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write_enable,
   input  wire logic [mwtg_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [mwtg_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output mwtg_pkg::cfg_type                        cfg
);

   mwtg_pkg::cfg_type cfg_ff;
   mwtg_pkg::cfg_type cfg_in;

   // Decode the write into the addressed register
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            mwtg_pkg::CSR_WAVE_MODE: begin
               cfg_in.wave_mode = csr_wdata[mwtg_pkg::MODE_W-1:0];
            end
            mwtg_pkg::CSR_PHASE_STEP: begin
               cfg_in.phase_step = csr_wdata[mwtg_pkg::STEP_W-1:0];
            end
            mwtg_pkg::CSR_AMPLITUDE_GAIN: begin
               cfg_in.amplitude_gain = csr_wdata[mwtg_pkg::GAIN_W-1:0];
            end
            mwtg_pkg::CSR_FILTER_ALPHA: begin
               cfg_in.filter_alpha = csr_wdata[mwtg_pkg::ALPHA_W-1:0];
            end
            mwtg_pkg::CSR_SAMPLE_COUNT: begin
               cfg_in.sample_count = csr_wdata[mwtg_pkg::COUNT_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   // Hold the registers, load defaults on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wave_mode      <= mwtg_pkg::RESET_WAVE_MODE;
         cfg_ff.phase_step     <= mwtg_pkg::RESET_PHASE_STEP;
         cfg_ff.amplitude_gain <= mwtg_pkg::RESET_GAIN;
         cfg_ff.filter_alpha   <= mwtg_pkg::RESET_ALPHA;
         cfg_ff.sample_count   <= mwtg_pkg::RESET_COUNT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ----- design/mwtg_seq.sv -----
// ----------------------------------------------------------------------------
// Tone generator sequencer
// Steps one request through the shared multiplier and owns both handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module mwtg_seq (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   input  wire logic [mwtg_pkg::MODE_W-1:0]   wave_mode,
   output mwtg_pkg::ctrl_type                 ctrl
);

   mwtg_pkg::state_type state_ff;
   mwtg_pkg::state_type state_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic                accept;
   logic                finish;

   // State register and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mwtg_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state, accept and finish
   always_comb begin
      state_in = state_ff;
      accept   = 1'b0;
      finish   = 1'b0;
      unique case (state_ff)
         mwtg_pkg::ST_IDLE: begin
            if (req_valid) begin
               accept   = 1'b1;
               state_in = mwtg_pkg::ST_RAW_A;
            end
         end
         mwtg_pkg::ST_RAW_A: begin
            state_in = (wave_mode == mwtg_pkg::MODE_SAWTOOTH) ? mwtg_pkg::ST_RAW_B
                                                              : mwtg_pkg::ST_RAW_C;
         end
         mwtg_pkg::ST_RAW_B:  state_in = mwtg_pkg::ST_RAW_C;
         mwtg_pkg::ST_RAW_C:  state_in = mwtg_pkg::ST_GAIN;
         mwtg_pkg::ST_GAIN:   state_in = mwtg_pkg::ST_SAT;
         mwtg_pkg::ST_SAT:    state_in = mwtg_pkg::ST_FILT_A;
         mwtg_pkg::ST_FILT_A: state_in = mwtg_pkg::ST_FILT_B;
         mwtg_pkg::ST_FILT_B: state_in = mwtg_pkg::ST_FILT_C;
         mwtg_pkg::ST_FILT_C: state_in = mwtg_pkg::ST_FILT_D;
         mwtg_pkg::ST_FILT_D: state_in = mwtg_pkg::ST_DONE;
         mwtg_pkg::ST_DONE: begin
            // wait until the output register is free or being emptied
            if (!rsp_valid_ff || !rsp_stall) begin
               finish   = 1'b1;
               state_in = mwtg_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mwtg_pkg::ST_IDLE;
         end
      endcase
   end

   // Set valid on finish, drop it once taken
   always_comb begin
      priority if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign req_stall   = (state_ff != mwtg_pkg::ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign ctrl.state  = state_ff;
   assign ctrl.accept = accept;
   assign ctrl.finish = finish;

endmodule

`default_nettype wire

// ----- design/mwtg_dp.sv -----
// ----------------------------------------------------------------------------
// Tone generator datapath
// Phase, toggle, index and filter state, the sine table and one shared
// registered multiplier used for waveform, gain and filter products.
// ----------------------------------------------------------------------------
`default_nettype none

module mwtg_dp (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  mwtg_pkg::ctrl_type                         ctrl,
   input  mwtg_pkg::cfg_type                          cfg,
   input  wire logic                                  req_restart,
   output logic signed [mwtg_pkg::SAMPLE_W-1:0]       rsp_sample,
   output logic                                       rsp_last
);

   localparam int ACC_W    = mwtg_pkg::ACC_W;
   localparam int SAMPLE_W = mwtg_pkg::SAMPLE_W;
   localparam logic signed [ACC_W-1:0] SAW_BIAS = ACC_W'(mwtg_pkg::AMP_MAX) << 32;
   localparam logic signed [ACC_W-1:0] SAT_HI   = ACC_W'(mwtg_pkg::AMP_MAX);
   localparam logic signed [ACC_W-1:0] SAT_LO   = ACC_W'(mwtg_pkg::AMP_MIN);

   // Run state
   logic [mwtg_pkg::PHASE_W-1:0]         phase_ff, phase_in;
   logic                                 square_ff, square_in;
   logic [mwtg_pkg::COUNT_W-1:0]         index_ff, index_in;
   logic signed [mwtg_pkg::PREV_W-1:0]   prev_ff, prev_in;

   // Working registers
   logic signed [mwtg_pkg::PROD_W-1:0]   prod_ff, prod_in;
   logic signed [ACC_W-1:0]              acc_ff, acc_in;
   logic signed [SAMPLE_W-1:0]           sine_ff, sine_in;
   logic signed [SAMPLE_W-1:0]           raw_ff, raw_in;
   logic signed [SAMPLE_W-1:0]           s_ff, s_in;
   logic signed [SAMPLE_W-1:0]           rsp_sample_ff, rsp_sample_in;
   logic                                 rsp_last_ff, rsp_last_in;

   // Shared multiplier
   logic                                 mul_en;
   logic signed [mwtg_pkg::MUL_A_W-1:0]  mul_a;
   logic signed [mwtg_pkg::MUL_B_W-1:0]  mul_b;
   logic signed [mwtg_pkg::PROD_W-1:0]   mul_a_ext, mul_b_ext;

   // Waveform helpers
   logic [15:0]                          p16;
   logic [16:0]                          tri_w;
   logic signed [18:0]                   tri_lin;
   logic [1:0]                           quad;
   logic [mwtg_pkg::SINE_IDX_W-1:0]      sine_idx, sine_idx_neg, rom_addr;
   logic [SAMPLE_W-1:0]                  sine_rom [mwtg_pkg::SINE_DEPTH];
   logic [SAMPLE_W-1:0]                  sine_mag;
   logic [mwtg_pkg::ALPHA_W-1:0]         alpha_c, beta;
   logic                                 last;
   logic signed [ACC_W-1:0]              saw_full, tri_full, gain_full;
   logic signed [ACC_W-1:0]              y_full, o_full;
   logic signed [mwtg_pkg::PREV_W-1:0]   y;

   // Constant quarter-wave table
   for (genvar g = 0; g < mwtg_pkg::SINE_DEPTH; g++) begin : g_sine
      assign sine_rom[g] = mwtg_pkg::sine_value(g);
   end

   // Phase-derived values
   assign p16          = phase_ff[mwtg_pkg::PHASE_W-1 -: 16];
   assign tri_w        = p16[15] ? 17'((17'h10000 - {1'b0, p16}) << 1) : {p16, 1'b0};
   assign tri_lin      = $signed({1'b0, tri_w, 1'b0}) - 19'sd65536;
   assign quad         = phase_ff[mwtg_pkg::PHASE_W-1 -: 2];
   assign sine_idx     = phase_ff[mwtg_pkg::PHASE_W-3 -: mwtg_pkg::SINE_IDX_W];
   assign sine_idx_neg = ~sine_idx + 1'b1;
   assign rom_addr     = quad[0] ? sine_idx_neg : sine_idx;
   assign sine_mag     = (quad[0] && sine_idx == '0) ? SAMPLE_W'(mwtg_pkg::AMP_MAX)
                                                     : sine_rom[rom_addr];

   // Filter coefficients, alpha above unity means bypass
   assign alpha_c = (cfg.filter_alpha > mwtg_pkg::Q16_ONE) ? mwtg_pkg::Q16_ONE
                                                          : cfg.filter_alpha;
   assign beta    = mwtg_pkg::Q16_ONE - alpha_c;

   assign last = (index_ff == cfg.sample_count - mwtg_pkg::COUNT_W'(1));

   // Post-multiply rounding
   assign saw_full  = mwtg_pkg::trunc_q32(ACC_W'(prod_ff) - SAW_BIAS);
   assign tri_full  = mwtg_pkg::trunc_q16(ACC_W'(prod_ff));
   assign gain_full = mwtg_pkg::trunc_q16(ACC_W'(prod_ff));
   assign y_full    = mwtg_pkg::trunc_q16(acc_ff);
   assign y         = y_full[mwtg_pkg::PREV_W-1:0];
   assign o_full    = mwtg_pkg::trunc_q16(ACC_W'(y));

   // Multiplier with registered product
   assign mul_a_ext = mwtg_pkg::PROD_W'(mul_a);
   assign mul_b_ext = mwtg_pkg::PROD_W'(mul_b);
   assign prod_in   = mul_en ? (mul_a_ext * mul_b_ext) : prod_ff;

   // Per-step operand selection and register updates
   always_comb begin
      phase_in      = phase_ff;
      square_in     = square_ff;
      index_in      = index_ff;
      prev_in       = prev_ff;
      acc_in        = acc_ff;
      sine_in       = sine_ff;
      raw_in        = raw_ff;
      s_in          = s_ff;
      rsp_sample_in = rsp_sample_ff;
      rsp_last_in   = rsp_last_ff;
      mul_en        = 1'b0;
      mul_a         = '0;
      mul_b         = '0;
      unique case (ctrl.state)
         mwtg_pkg::ST_IDLE: begin
            // clear the run before this sample on restart
            if (ctrl.accept && req_restart) begin
               phase_in  = '0;
               square_in = 1'b1;
               index_in  = '0;
               prev_in   = '0;
            end
         end
         mwtg_pkg::ST_RAW_A: begin
            mul_en  = 1'b1;
            sine_in = quad[1] ? -$signed(sine_mag) : $signed(sine_mag);
            if (cfg.wave_mode == mwtg_pkg::MODE_TRIANGLE) begin
               mul_a = mwtg_pkg::MUL_A_W'(tri_lin);
               mul_b = 18'sd32767;
            end else begin
               mul_a = $signed({{(mwtg_pkg::MUL_A_W-16){1'b0}}, p16});
               mul_b = $signed({2'b00, p16});
            end
         end
         mwtg_pkg::ST_RAW_B: begin
            // sawtooth: p16 squared times two times full scale
            mul_en = 1'b1;
            mul_a  = $signed({1'b0, prod_ff[31:0]});
            mul_b  = 18'sd65534;
         end
         mwtg_pkg::ST_RAW_C: begin
            unique case (cfg.wave_mode)
               mwtg_pkg::MODE_SQUARE: begin
                  raw_in = square_ff ? SAMPLE_W'(mwtg_pkg::AMP_MAX)
                                     : SAMPLE_W'(mwtg_pkg::AMP_MIN);
               end
               mwtg_pkg::MODE_SAWTOOTH: raw_in = saw_full[SAMPLE_W-1:0];
               mwtg_pkg::MODE_TRIANGLE: raw_in = tri_full[SAMPLE_W-1:0];
               mwtg_pkg::MODE_SINE:     raw_in = sine_ff;
               default:                 raw_in = sine_ff;
            endcase
         end
         mwtg_pkg::ST_GAIN: begin
            mul_en = 1'b1;
            mul_a  = mwtg_pkg::MUL_A_W'(raw_ff);
            mul_b  = $signed({1'b0, cfg.amplitude_gain});
         end
         mwtg_pkg::ST_SAT: begin
            priority if (gain_full > SAT_HI) begin
               s_in = SAMPLE_W'(mwtg_pkg::AMP_MAX);
            end else if (gain_full < SAT_LO) begin
               s_in = SAMPLE_W'(mwtg_pkg::AMP_MIN);
            end else begin
               s_in = gain_full[SAMPLE_W-1:0];
            end
         end
         mwtg_pkg::ST_FILT_A: begin
            mul_en = 1'b1;
            mul_a  = mwtg_pkg::MUL_A_W'(s_ff);
            mul_b  = $signed({1'b0, alpha_c});
         end
         mwtg_pkg::ST_FILT_B: begin
            // alpha*x scaled up, then beta times low half of previous
            acc_in = ACC_W'(prod_ff) <<< 16;
            mul_en = 1'b1;
            mul_a  = $signed({{(mwtg_pkg::MUL_A_W-16){1'b0}}, prev_ff[15:0]});
            mul_b  = $signed({1'b0, beta});
         end
         mwtg_pkg::ST_FILT_C: begin
            acc_in = acc_ff + ACC_W'(prod_ff);
            mul_en = 1'b1;
            mul_a  = mwtg_pkg::MUL_A_W'(prev_ff >>> 16);
            mul_b  = $signed({1'b0, beta});
         end
         mwtg_pkg::ST_FILT_D: begin
            acc_in = acc_ff + (ACC_W'(prod_ff) <<< 16);
         end
         mwtg_pkg::ST_DONE: begin
            // emit the sample and advance the run
            if (ctrl.finish) begin
               rsp_sample_in = o_full[SAMPLE_W-1:0];
               rsp_last_in   = last;
               if (last) begin
                  phase_in  = '0;
                  square_in = 1'b1;
                  index_in  = '0;
                  prev_in   = '0;
               end else begin
                  phase_in  = phase_ff + cfg.phase_step;
                  square_in = ~square_ff;
                  index_in  = index_ff + 1'b1;
                  prev_in   = y;
               end
            end
         end
         default: begin
            mul_en = 1'b0;
         end
      endcase
   end

   // Run state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= '0;
         square_ff <= 1'b1;
         index_ff  <= '0;
         prev_ff   <= '0;
      end else begin
         phase_ff  <= phase_in;
         square_ff <= square_in;
         index_ff  <= index_in;
         prev_ff   <= prev_in;
      end
   end

   // Working and output payload registers
   always_ff @(posedge clock) begin
      prod_ff       <= prod_in;
      acc_ff        <= acc_in;
      sine_ff       <= sine_in;
      raw_ff        <= raw_in;
      s_ff          <= s_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_sample = rsp_sample_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

`default_nettype wire

// ----- design/mwtg_checker.sv -----
// ----------------------------------------------------------------------------
// Tone generator port checker
// Concurrent checks on the top-level handshakes, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "multi_waveform_tone_generator_macros.svh"

module mwtg_checker (
   input wire logic                                  clock,
   input wire logic                                  reset,
   input wire logic                                  req_valid,
   input wire logic                                  req_stall,
   input wire logic                                  rsp_valid,
   input wire logic                                  rsp_stall,
   input wire logic signed [mwtg_pkg::SAMPLE_W-1:0]  rsp_sample,
   input wire logic                                  rsp_last
);

   // Still busy at a later point of the sequence after a request is taken
   `MWTG_ASSERT_SAME(a_busy_after_req, clock, reset, req_valid && !req_stall, ##9 req_stall, "request taken but block free again too early")

   // Stalled response holds
   `MWTG_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_sample) && $stable(rsp_last), "stalled response changed")

   // A new response only follows work in progress
   `MWTG_ASSERT_SAME(a_rsp_from_work, clock, reset, $rose(rsp_valid), $past(req_stall), "response appeared without a request in flight")

   // Idle and response taken: nothing follows
   `MWTG_ASSERT_NEXT(a_no_extra_rsp, clock, reset, rsp_valid && !rsp_stall && !req_stall, !rsp_valid, "extra response while idle")

endmodule

bind multi_waveform_tone_generator mwtg_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_stall  (req_stall),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_sample (rsp_sample),
   .rsp_last   (rsp_last)
);

`default_nettype wire
